// ===== rtl/core/imh_pkg.sv =====
// ----------------------------------------------------------------------------
// imh_pkg
// Shared types, sizes and codes for the indexed min-heap decrease-key unit.
// ----------------------------------------------------------------------------
package imh_pkg;

   localparam int NUM_ITEMS  = 1024;
   localparam int ITEM_W     = 10;
   localparam int KEY_W      = 30;
   localparam int SLOT_W     = 11;
   localparam int CAPACITY   = 1024;
   // ids are distinct, so the heap never holds more than NUM_ITEMS entries
   localparam int EFF_CAP    = (CAPACITY < NUM_ITEMS) ? CAPACITY : NUM_ITEMS;
   localparam int HEAP_AW    = $clog2(EFF_CAP);
   localparam int HEAP_DEPTH = 1 << HEAP_AW;
   localparam logic [SLOT_W-1:0] CAP_SLOTS = SLOT_W'(EFF_CAP);

   localparam logic [1:0] KIND_PUSH = 2'd0;
   localparam logic [1:0] KIND_POP  = 2'd1;
   localparam logic [1:0] KIND_DEC  = 2'd2;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_POP_EMPTY = 3'd1;
   localparam logic [2:0] STATUS_PUSH_FULL = 3'd2;
   localparam logic [2:0] STATUS_PRESENT   = 3'd3;
   localparam logic [2:0] STATUS_NOT_LOWER = 3'd4;

   localparam int STEP_W = 5;
   localparam logic [STEP_W-1:0] STEP_NONE      = 5'd0;
   localparam logic [STEP_W-1:0] STEP_CLEAR     = 5'd1;
   localparam logic [STEP_W-1:0] STEP_ACCEPT    = 5'd2;
   localparam logic [STEP_W-1:0] STEP_SET_STAT  = 5'd3;
   localparam logic [STEP_W-1:0] STEP_PUSH_GO   = 5'd4;
   localparam logic [STEP_W-1:0] STEP_DEC_STORE = 5'd5;
   localparam logic [STEP_W-1:0] STEP_DEC_GO    = 5'd6;
   localparam logic [STEP_W-1:0] STEP_POP_RD_ID = 5'd7;
   localparam logic [STEP_W-1:0] STEP_POP_RD_KY = 5'd8;
   localparam logic [STEP_W-1:0] STEP_POP_LAST  = 5'd9;
   localparam logic [STEP_W-1:0] STEP_POP_MOVE  = 5'd10;
   localparam logic [STEP_W-1:0] STEP_UP_RD     = 5'd11;
   localparam logic [STEP_W-1:0] STEP_UP_ID     = 5'd12;
   localparam logic [STEP_W-1:0] STEP_UP_MOVE   = 5'd13;
   localparam logic [STEP_W-1:0] STEP_DN_RD     = 5'd14;
   localparam logic [STEP_W-1:0] STEP_DN_ID     = 5'd15;
   localparam logic [STEP_W-1:0] STEP_DN_MOVE   = 5'd16;
   localparam logic [STEP_W-1:0] STEP_PLACE     = 5'd17;

   typedef struct packed {
      logic [1:0]        kind;
      logic [ITEM_W-1:0] item;
      logic [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      logic [ITEM_W-1:0] out_item;
      logic [KEY_W-1:0]  out_key;
      logic [2:0]        status;
      logic [SLOT_W-1:0] count;
   } rsp_type;

   typedef struct packed {
      logic [STEP_W-1:0] step;
      logic [2:0]        status;
   } cmd_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       present;
      logic       in_heap;
      logic       full;
      logic       empty;
      logic       not_lower;
      logic       last_one;
      logic       at_root;
      logic       up_move;
      logic       leaf;
      logic       dn_stop;
      logic       clear_done;
   } flags_type;

endpackage

// ===== rtl/core/imh_datapath.sv =====
// ----------------------------------------------------------------------------
// imh_datapath
// Heap slot memory, key store, position map and the sift registers.
// ----------------------------------------------------------------------------
module imh_datapath (
   input  logic               clock,
   input  logic               reset,
   input  imh_pkg::cmd_type   cmd,
   input  imh_pkg::req_type   req_data,
   output imh_pkg::flags_type flags,
   output imh_pkg::rsp_type   rsp_data
);

   localparam int SW = imh_pkg::SLOT_W;
   localparam int IW = imh_pkg::ITEM_W;
   localparam int KW = imh_pkg::KEY_W;

   logic [IW-1:0] heap_mem [imh_pkg::HEAP_DEPTH];
   logic [KW-1:0] key_mem  [imh_pkg::NUM_ITEMS];
   logic [SW-1:0] pos_mem  [imh_pkg::NUM_ITEMS];

   imh_pkg::req_type req_ff;
   logic [SW-1:0] cur_ff, cur_in, count_ff, count_in;
   logic [IW-1:0] mov_id_ff, mov_id_in;
   logic [KW-1:0] mov_key_ff, mov_key_in;
   logic [IW-1:0] out_item_ff, out_item_in;
   logic [KW-1:0] out_key_ff, out_key_in;
   logic [2:0]    status_ff, status_in;
   logic [IW-1:0] clr_ff;

   logic [IW-1:0] heap_a_ff, heap_b_ff;
   logic [KW-1:0] key_a_ff, key_b_ff;
   logic [SW-1:0] pos_rd_ff;

   logic          heap_rd_en;
   logic [SW:0]   heap_a_slot, heap_b_slot;
   logic          key_a_en, key_b_en;
   logic [IW-1:0] key_a_addr;
   logic          key_we;
   logic          heap_we;
   logic [SW:0]   heap_w_slot;
   logic [IW-1:0] heap_w_data;
   logic          pos_we;
   logic [IW-1:0] pos_w_addr;
   logic [SW-1:0] pos_w_data;

   logic [SW:0]   child, child_r, pick_slot;
   logic          pick_right;
   logic [IW-1:0] pick_id;
   logic [KW-1:0] pick_key;

   function automatic logic [imh_pkg::HEAP_AW-1:0] slot_addr(input logic [SW:0] s);
      logic [SW:0] t;
      t = s - {{SW{1'b0}}, 1'b1};
      return t[imh_pkg::HEAP_AW-1:0];
   endfunction

   assign child      = {cur_ff, 1'b0};
   assign child_r    = {cur_ff, 1'b1};
   assign pick_right = (child < {1'b0, count_ff}) && (key_a_ff > key_b_ff);
   assign pick_id    = pick_right ? heap_b_ff : heap_a_ff;
   assign pick_key   = pick_right ? key_b_ff : key_a_ff;
   assign pick_slot  = pick_right ? child_r : child;

   // memory port selection per step
   always_comb begin
      heap_rd_en  = 1'b0;
      heap_a_slot = {(SW + 1){1'b0}};
      heap_b_slot = {(SW + 1){1'b0}};
      key_a_en    = 1'b0;
      key_b_en    = 1'b0;
      key_a_addr  = heap_a_ff;
      key_we      = 1'b0;
      heap_we     = 1'b0;
      heap_w_slot = {1'b0, cur_ff};
      heap_w_data = mov_id_ff;
      pos_we      = 1'b0;
      pos_w_addr  = mov_id_ff;
      pos_w_data  = cur_ff;
      case (cmd.step)
         imh_pkg::STEP_CLEAR: begin
            pos_we     = 1'b1;
            pos_w_addr = clr_ff;
            pos_w_data = {SW{1'b0}};
         end
         imh_pkg::STEP_ACCEPT: begin
            key_a_en   = 1'b1;
            key_a_addr = req_data.item;
         end
         imh_pkg::STEP_PUSH_GO,
         imh_pkg::STEP_DEC_STORE,
         imh_pkg::STEP_DEC_GO: begin
            key_we = 1'b1;
         end
         imh_pkg::STEP_POP_RD_ID: begin
            heap_rd_en  = 1'b1;
            heap_a_slot = {{SW{1'b0}}, 1'b1};
            heap_b_slot = {1'b0, count_ff};
         end
         imh_pkg::STEP_POP_RD_KY,
         imh_pkg::STEP_DN_ID: begin
            key_a_en = 1'b1;
            key_b_en = 1'b1;
         end
         imh_pkg::STEP_POP_LAST,
         imh_pkg::STEP_POP_MOVE: begin
            pos_we     = 1'b1;
            pos_w_addr = heap_a_ff;
            pos_w_data = {SW{1'b0}};
         end
         imh_pkg::STEP_UP_RD: begin
            heap_rd_en  = 1'b1;
            heap_a_slot = {2'b00, cur_ff[SW-1:1]};
         end
         imh_pkg::STEP_UP_ID: begin
            key_a_en = 1'b1;
         end
         imh_pkg::STEP_UP_MOVE: begin
            heap_we     = 1'b1;
            heap_w_data = heap_a_ff;
            pos_we      = 1'b1;
            pos_w_addr  = heap_a_ff;
         end
         imh_pkg::STEP_DN_RD: begin
            heap_rd_en  = 1'b1;
            heap_a_slot = child;
            heap_b_slot = child_r;
         end
         imh_pkg::STEP_DN_MOVE: begin
            heap_we     = 1'b1;
            heap_w_data = pick_id;
            pos_we      = 1'b1;
            pos_w_addr  = pick_id;
         end
         imh_pkg::STEP_PLACE: begin
            heap_we = 1'b1;
            pos_we  = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (heap_we) begin
         heap_mem[slot_addr(heap_w_slot)] <= heap_w_data;
      end
      if (heap_rd_en) begin
         heap_a_ff <= heap_mem[slot_addr(heap_a_slot)];
         heap_b_ff <= heap_mem[slot_addr(heap_b_slot)];
      end
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[req_ff.item] <= req_ff.key;
      end
      if (key_a_en) begin
         key_a_ff <= key_mem[key_a_addr];
      end
      if (key_b_en) begin
         key_b_ff <= key_mem[heap_b_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_w_addr] <= pos_w_data;
      end
      if (cmd.step == imh_pkg::STEP_ACCEPT) begin
         pos_rd_ff <= pos_mem[req_data.item];
      end
   end

   // register transfers per step
   always_comb begin
      cur_in      = cur_ff;
      count_in    = count_ff;
      mov_id_in   = mov_id_ff;
      mov_key_in  = mov_key_ff;
      out_item_in = out_item_ff;
      out_key_in  = out_key_ff;
      status_in   = status_ff;
      case (cmd.step)
         imh_pkg::STEP_ACCEPT: begin
            out_item_in = {IW{1'b0}};
            out_key_in  = {KW{1'b0}};
            status_in   = imh_pkg::STATUS_OK;
         end
         imh_pkg::STEP_SET_STAT: begin
            status_in = cmd.status;
         end
         imh_pkg::STEP_PUSH_GO: begin
            count_in   = count_ff + 1'b1;
            cur_in     = count_ff + 1'b1;
            mov_id_in  = req_ff.item;
            mov_key_in = req_ff.key;
         end
         imh_pkg::STEP_DEC_GO: begin
            cur_in     = pos_rd_ff;
            mov_id_in  = req_ff.item;
            mov_key_in = req_ff.key;
         end
         imh_pkg::STEP_POP_LAST: begin
            out_item_in = heap_a_ff;
            out_key_in  = key_a_ff;
            count_in    = {SW{1'b0}};
         end
         imh_pkg::STEP_POP_MOVE: begin
            out_item_in = heap_a_ff;
            out_key_in  = key_a_ff;
            mov_id_in   = heap_b_ff;
            mov_key_in  = key_b_ff;
            count_in    = count_ff - 1'b1;
            cur_in      = {{(SW - 1){1'b0}}, 1'b1};
         end
         imh_pkg::STEP_UP_MOVE: begin
            cur_in = {1'b0, cur_ff[SW-1:1]};
         end
         imh_pkg::STEP_DN_MOVE: begin
            cur_in = pick_slot[SW-1:0];
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= {SW{1'b0}};
         clr_ff   <= {IW{1'b0}};
      end else begin
         count_ff <= count_in;
         if (cmd.step == imh_pkg::STEP_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step == imh_pkg::STEP_ACCEPT) begin
         req_ff <= req_data;
      end
      cur_ff      <= cur_in;
      mov_id_ff   <= mov_id_in;
      mov_key_ff  <= mov_key_in;
      out_item_ff <= out_item_in;
      out_key_ff  <= out_key_in;
      status_ff   <= status_in;
   end

   always_comb begin
      flags.kind       = req_ff.kind;
      flags.present    = (pos_rd_ff != {SW{1'b0}});
      flags.in_heap    = (pos_rd_ff != {SW{1'b0}}) && (pos_rd_ff <= count_ff);
      flags.full       = (count_ff >= imh_pkg::CAP_SLOTS);
      flags.empty      = (count_ff == {SW{1'b0}});
      flags.not_lower  = (req_ff.key >= key_a_ff);
      flags.last_one   = (count_ff == {{(SW - 1){1'b0}}, 1'b1});
      flags.at_root    = (cur_ff <= {{(SW - 1){1'b0}}, 1'b1});
      flags.up_move    = (key_a_ff > mov_key_ff);
      flags.leaf       = (child > {1'b0, count_ff});
      flags.dn_stop    = (pick_key > mov_key_ff);
      flags.clear_done = (clr_ff == {IW{1'b1}});
   end

   assign rsp_data.out_item = out_item_ff;
   assign rsp_data.out_key  = out_key_ff;
   assign rsp_data.status   = status_ff;
   assign rsp_data.count    = count_ff;

endmodule

// ===== rtl/core/imh_ctrl.sv =====
// ----------------------------------------------------------------------------
// imh_ctrl
// Sequencer: clearing pass, request check, sift-up and sift-down loops.
// ----------------------------------------------------------------------------
module imh_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  imh_pkg::flags_type flags,
   output imh_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);

   localparam logic [3:0] S_CLEAR    = 4'd0;
   localparam logic [3:0] S_IDLE     = 4'd1;
   localparam logic [3:0] S_CHECK    = 4'd2;
   localparam logic [3:0] S_POP_KEY  = 4'd3;
   localparam logic [3:0] S_POP_TAKE = 4'd4;
   localparam logic [3:0] S_UP_RD    = 4'd5;
   localparam logic [3:0] S_UP_ID    = 4'd6;
   localparam logic [3:0] S_UP_KEY   = 4'd7;
   localparam logic [3:0] S_DN_RD    = 4'd8;
   localparam logic [3:0] S_DN_ID    = 4'd9;
   localparam logic [3:0] S_DN_KEY   = 4'd10;
   localparam logic [3:0] S_DONE     = 4'd11;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.step   = imh_pkg::STEP_NONE;
      cmd.status = imh_pkg::STATUS_OK;
      case (state_ff)
         S_CLEAR: begin
            cmd.step = imh_pkg::STEP_CLEAR;
            if (flags.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.step = imh_pkg::STEP_ACCEPT;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = S_DONE;
            case (flags.kind)
               imh_pkg::KIND_PUSH: begin
                  if (flags.present) begin
                     cmd.step   = imh_pkg::STEP_SET_STAT;
                     cmd.status = imh_pkg::STATUS_PRESENT;
                  end else if (flags.full) begin
                     cmd.step   = imh_pkg::STEP_SET_STAT;
                     cmd.status = imh_pkg::STATUS_PUSH_FULL;
                  end else begin
                     cmd.step = imh_pkg::STEP_PUSH_GO;
                     state_in = S_UP_RD;
                  end
               end
               imh_pkg::KIND_POP: begin
                  if (flags.empty) begin
                     cmd.step   = imh_pkg::STEP_SET_STAT;
                     cmd.status = imh_pkg::STATUS_POP_EMPTY;
                  end else begin
                     cmd.step = imh_pkg::STEP_POP_RD_ID;
                     state_in = S_POP_KEY;
                  end
               end
               imh_pkg::KIND_DEC: begin
                  if (!flags.in_heap) begin
                     cmd.step = imh_pkg::STEP_DEC_STORE;
                  end else if (flags.not_lower) begin
                     cmd.step   = imh_pkg::STEP_SET_STAT;
                     cmd.status = imh_pkg::STATUS_NOT_LOWER;
                  end else begin
                     cmd.step = imh_pkg::STEP_DEC_GO;
                     state_in = S_UP_RD;
                  end
               end
               default: begin
               end
            endcase
         end
         S_POP_KEY: begin
            cmd.step = imh_pkg::STEP_POP_RD_KY;
            state_in = S_POP_TAKE;
         end
         S_POP_TAKE: begin
            if (flags.last_one) begin
               cmd.step = imh_pkg::STEP_POP_LAST;
               state_in = S_DONE;
            end else begin
               cmd.step = imh_pkg::STEP_POP_MOVE;
               state_in = S_DN_RD;
            end
         end
         S_UP_RD: begin
            if (flags.at_root) begin
               cmd.step = imh_pkg::STEP_PLACE;
               state_in = S_DONE;
            end else begin
               cmd.step = imh_pkg::STEP_UP_RD;
               state_in = S_UP_ID;
            end
         end
         S_UP_ID: begin
            cmd.step = imh_pkg::STEP_UP_ID;
            state_in = S_UP_KEY;
         end
         S_UP_KEY: begin
            if (flags.up_move) begin
               cmd.step = imh_pkg::STEP_UP_MOVE;
               state_in = S_UP_RD;
            end else begin
               cmd.step = imh_pkg::STEP_PLACE;
               state_in = S_DONE;
            end
         end
         S_DN_RD: begin
            if (flags.leaf) begin
               cmd.step = imh_pkg::STEP_PLACE;
               state_in = S_DONE;
            end else begin
               cmd.step = imh_pkg::STEP_DN_RD;
               state_in = S_DN_ID;
            end
         end
         S_DN_ID: begin
            cmd.step = imh_pkg::STEP_DN_ID;
            state_in = S_DN_KEY;
         end
         S_DN_KEY: begin
            if (flags.dn_stop) begin
               cmd.step = imh_pkg::STEP_PLACE;
               state_in = S_DONE;
            end else begin
               cmd.step = imh_pkg::STEP_DN_MOVE;
               state_in = S_DN_RD;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

`ifndef NO_ASSERTIONS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");
   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_CHECK))
      else $error("accepted transaction did not reach the check step");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("block stayed busy after delivering a result");
`endif

endmodule

// ===== rtl/core/indexed_min_heap_decrease_key_unit.sv =====
// ----------------------------------------------------------------------------
// indexed_min_heap_decrease_key_unit
// Indexed binary min-heap of item ids with key store and position map.
// ----------------------------------------------------------------------------
// Raise start with a transaction on req_data while busy is low; exactly one
// result follows on rsp_data, flagged by rsp_valid for a single cycle, and it
// must be captured then since it is not held. After reset the block clears
// all 1024 entries of its position map with busy high. Errors and a store-only
// decrease pass through the idle, check and result states; a pop also reads the
// top and last entries, and a sift adds, for each heap level it moves past, a
// slot read, a key read and a compare/move, then settles the moving entry; the
// registered reads of the heap slot memory and the key store set those
// per-level steps.
module indexed_min_heap_decrease_key_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  imh_pkg::req_type req_data,
   output logic             rsp_valid,
   output imh_pkg::rsp_type rsp_data
);

   // controller/datapath handshake
   imh_pkg::cmd_type   cmd;
   imh_pkg::flags_type flags;

   // sequence the clearing pass, checks and the sift loops
   imh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .flags     (flags),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // hold the memories, the moving entry and the result registers
   imh_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_data (req_data),
      .flags    (flags),
      .rsp_data (rsp_data)
   );

endmodule

// ===== test/tb_indexed_min_heap_decrease_key_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_decrease_key_unit
// Self-checking bench for the indexed min-heap with decrease-key.
// ----------------------------------------------------------------------------
// A local shadow heap (slots, position map, key store) predicts the result of
// every accepted transaction. Directed tests hit the corner cases, a full-heap
// test fills all 1024 ids and drains part of the heap, and a random test
// mixes well-formed push/pop/decrease traffic with noise under several sender
// idle rates.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_decrease_key_unit;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int EXP_DEPTH   = 8;
   localparam logic [1:0] KIND_NOP = 2'd3;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   imh_pkg::req_type req_data = '0;
   logic             rsp_valid;
   imh_pkg::rsp_type rsp_data;

   indexed_min_heap_decrease_key_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow heap state, 1-based slots, slot 0 in the position map means absent.
   logic [imh_pkg::ITEM_W-1:0] shadow_slot [1:imh_pkg::NUM_ITEMS];
   logic [imh_pkg::SLOT_W-1:0] shadow_pos  [imh_pkg::NUM_ITEMS];
   logic [imh_pkg::KEY_W-1:0]  shadow_key  [imh_pkg::NUM_ITEMS];
   int unsigned                shadow_count;

   // Expected results in order of acceptance.
   imh_pkg::rsp_type exp_mem [EXP_DEPTH];
   int unsigned exp_wr     = 0;
   int unsigned exp_rd     = 0;
   int unsigned errors     = 0;
   int unsigned ops_sent   = 0;
   int unsigned rsp_seen   = 0;
   int unsigned pops_ok    = 0;
   int unsigned idle_pct   = 0;
   int unsigned cycle_cnt  = 0;

   function automatic void shadow_place(int unsigned slot,
                                        logic [imh_pkg::ITEM_W-1:0] id);
      shadow_slot[slot] = id;
      shadow_pos[id]    = imh_pkg::SLOT_W'(slot);
   endfunction

   // Move strictly greater parents down until the moving key settles.
   function automatic void shadow_sift_up(int unsigned slot);
      logic [imh_pkg::ITEM_W-1:0] id;
      logic [imh_pkg::KEY_W-1:0]  k;
      id = shadow_slot[slot];
      k  = shadow_key[id];
      while (slot > 1 && shadow_key[shadow_slot[slot/2]] > k) begin
         shadow_place(slot, shadow_slot[slot/2]);
         slot = slot / 2;
      end
      shadow_place(slot, id);
   endfunction

   // Prefer the left child on ties; pass children with equal keys too.
   function automatic void shadow_sift_down(int unsigned slot);
      logic [imh_pkg::ITEM_W-1:0] id;
      logic [imh_pkg::KEY_W-1:0]  k;
      int unsigned                child;
      id    = shadow_slot[slot];
      k     = shadow_key[id];
      child = slot * 2;
      while (child <= shadow_count) begin
         if (child < shadow_count &&
             shadow_key[shadow_slot[child]] > shadow_key[shadow_slot[child+1]])
            child++;
         if (shadow_key[shadow_slot[child]] > k) break;
         shadow_place(slot, shadow_slot[child]);
         slot  = child;
         child = slot * 2;
      end
      shadow_place(slot, id);
   endfunction

   function automatic imh_pkg::rsp_type heap_apply(imh_pkg::req_type r);
      imh_pkg::rsp_type           res;
      int unsigned                s;
      logic [imh_pkg::ITEM_W-1:0] top;
      res = '0;
      res.status = imh_pkg::STATUS_OK;
      case (r.kind)
         imh_pkg::KIND_PUSH: begin
            if (shadow_pos[r.item] != 0) res.status = imh_pkg::STATUS_PRESENT;
            else if (shadow_count >= imh_pkg::EFF_CAP)
               res.status = imh_pkg::STATUS_PUSH_FULL;
            else begin
               shadow_key[r.item] = r.key;
               shadow_count++;
               shadow_place(shadow_count, r.item);
               shadow_sift_up(shadow_count);
            end
         end
         imh_pkg::KIND_POP: begin
            if (shadow_count == 0) res.status = imh_pkg::STATUS_POP_EMPTY;
            else begin
               top          = shadow_slot[1];
               res.out_item = top;
               res.out_key  = shadow_key[top];
               shadow_pos[top] = '0;
               if (shadow_count > 1) begin
                  shadow_place(1, shadow_slot[shadow_count]);
                  shadow_count--;
                  shadow_sift_down(1);
               end else begin
                  shadow_count = 0;
               end
            end
         end
         imh_pkg::KIND_DEC: begin
            s = shadow_pos[r.item];
            if (s == 0 || s > shadow_count) shadow_key[r.item] = r.key;
            else if (r.key >= shadow_key[r.item])
               res.status = imh_pkg::STATUS_NOT_LOWER;
            else begin
               shadow_key[r.item] = r.key;
               shadow_sift_up(s);
            end
         end
         default: ;
      endcase
      res.count = imh_pkg::SLOT_W'(shadow_count);
      return res;
   endfunction

   // Send one transaction: optional idle gap, then hold start until accepted.
   task automatic send_op(logic [1:0] kind, logic [imh_pkg::ITEM_W-1:0] item,
                          logic [imh_pkg::KEY_W-1:0] key);
      imh_pkg::req_type r;
      imh_pkg::rsp_type res;
      int               gap;
      r.kind = kind;
      r.item = item;
      r.key  = key;
      @(negedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         gap = $urandom_range(6, 1);
         repeat (gap) @(negedge clock);
      end
      start    = 1'b1;
      req_data = r;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      res = heap_apply(r);
      exp_mem[exp_wr % EXP_DEPTH] = res;
      exp_wr++;
      if (kind == imh_pkg::KIND_POP && res.status == imh_pkg::STATUS_OK) pops_ok++;
      ops_sent++;
   endtask

   // Hold off the sender until every expected result has come back.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (exp_wr != exp_rd) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Compare every strobed result with the oldest expectation.
   always @(posedge clock) begin
      imh_pkg::rsp_type want;
      cycle_cnt <= cycle_cnt + 1;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (exp_wr == exp_rd) begin
            $error("unexpected result item=%0d key=%0d status=%0d count=%0d",
                   rsp_data.out_item, rsp_data.out_key, rsp_data.status,
                   rsp_data.count);
            errors++;
         end else begin
            want = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_data.out_item !== want.out_item) begin
               $error("out_item expected %0d got %0d", want.out_item, rsp_data.out_item);
               errors++;
            end
            if (rsp_data.out_key !== want.out_key) begin
               $error("out_key expected %0d got %0d", want.out_key, rsp_data.out_key);
               errors++;
            end
            if (rsp_data.status !== want.status) begin
               $error("status expected %0d got %0d", want.status, rsp_data.status);
               errors++;
            end
            if (rsp_data.count !== want.count) begin
               $error("count expected %0d got %0d", want.count, rsp_data.count);
               errors++;
            end
         end
      end
   end

   // Watchdog: covers the clearing pass after reset and every slow sift.
   always @(posedge clock) begin
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_cnt);
         $display("FAIL indexed_min_heap_decrease_key_unit");
         $finish;
      end
   end

   // Corner cases: empty pop, key and id extremes, every reachable status, unused kind.
   task automatic test_directed();
      send_op(imh_pkg::KIND_POP, 10'd5, 30'd0);                  // pop from empty
      send_op(imh_pkg::KIND_PUSH, 10'd0, 30'd0);
      send_op(imh_pkg::KIND_PUSH, 10'd1023, 30'h3FFF_FFFF);
      send_op(imh_pkg::KIND_PUSH, 10'd0, 30'd7);                 // already present
      send_op(imh_pkg::KIND_PUSH, 10'd512, 30'd100);
      send_op(imh_pkg::KIND_PUSH, 10'd341, 30'd100);             // equal keys
      send_op(imh_pkg::KIND_PUSH, 10'd682, 30'h2AAA_AAAA);
      send_op(imh_pkg::KIND_DEC, 10'd512, 30'd100);              // key not lower
      send_op(imh_pkg::KIND_DEC, 10'd512, 30'd200);              // key higher
      send_op(imh_pkg::KIND_DEC, 10'd1023, 30'd1);               // lower, sifts up
      send_op(imh_pkg::KIND_DEC, 10'd777, 30'd3);                // absent: store only
      send_op(KIND_NOP, 10'h3FF, 30'h3FFF_FFFF);                 // unused kind
      send_op(imh_pkg::KIND_DEC, 10'd682, 30'd0);
      repeat (7) send_op(imh_pkg::KIND_POP, 10'h3FF, 30'd0);     // drain, last, empty
      send_op(imh_pkg::KIND_PUSH, 10'd777, 30'd9);               // push after absent dec
      send_op(imh_pkg::KIND_POP, 10'd0, 30'd0);
   endtask

   // Fill all 1024 ids, push a present id into the full heap, send decreases, then pop part.
   task automatic test_full_heap();
      int i;
      for (i = 0; i < imh_pkg::NUM_ITEMS; i++)
         send_op(imh_pkg::KIND_PUSH, imh_pkg::ITEM_W'((i * 389) % imh_pkg::NUM_ITEMS),
                 ($urandom_range(3) == 0) ? imh_pkg::KEY_W'($urandom_range(15))
                                          : imh_pkg::KEY_W'($urandom));
      send_op(imh_pkg::KIND_PUSH, 10'd17, 30'd5);
      for (i = 0; i < 20; i++)
         send_op(imh_pkg::KIND_DEC, shadow_slot[$urandom_range(imh_pkg::NUM_ITEMS, 1)],
                 imh_pkg::KEY_W'($urandom_range(20)));
      for (i = 0; i < 250; i++)
         send_op(imh_pkg::KIND_POP, imh_pkg::ITEM_W'($urandom), 30'd0);
   endtask

   // Mostly well-formed traffic with random content, some noise.
   task automatic test_random(int unsigned n_ops);
      int unsigned i, sel, pool;
      logic [imh_pkg::ITEM_W-1:0] id;
      logic [imh_pkg::KEY_W-1:0]  k, old;
      for (i = 0; i < n_ops; i++) begin
         pool = ($urandom_range(3) == 0) ? 1023 : 63;
         id   = imh_pkg::ITEM_W'($urandom_range(pool));
         k    = ($urandom_range(1) == 0) ? imh_pkg::KEY_W'($urandom_range(31))
                                         : imh_pkg::KEY_W'($urandom);
         sel  = $urandom_range(99);
         if (sel < 45) send_op(imh_pkg::KIND_PUSH, id, k);
         else if (sel < 75) send_op(imh_pkg::KIND_POP, id, k);
         else if (sel < 92 && shadow_count != 0) begin
            id  = shadow_slot[$urandom_range(shadow_count, 1)];
            old = shadow_key[id];
            if ($urandom_range(4) != 0 && old != 0)
               k = old - imh_pkg::KEY_W'($urandom_range((old > 64) ? 64 : old, 1));
            send_op(imh_pkg::KIND_DEC, id, k);
         end else if (sel < 97) send_op(imh_pkg::KIND_DEC, id, k);
         else send_op(KIND_NOP, id, k);
      end
   endtask

   initial begin
      int i;
      for (i = 0; i < imh_pkg::NUM_ITEMS; i++) shadow_pos[i] = '0;
      shadow_count = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      drain();
      test_full_heap();
      drain();
      idle_pct = 0;  test_random(70);
      drain();
      idle_pct = 70; test_random(70);
      idle_pct = 34; test_random(70);

      drain();
      $display("ran %0d transactions (%0d results checked, %0d nonempty pops)",
               ops_sent, rsp_seen, pops_ok);
      $display("covered every reachable status, the full heap, and idle rates 0/70/34 percent");
      if (errors == 0) begin
         $display("PASS indexed_min_heap_decrease_key_unit");
      end else begin
         $display("FAIL indexed_min_heap_decrease_key_unit");
      end
      $finish;
   end

endmodule
